### src/cdc_pkg.sv
// Package for the content defined chunker: payload types, register codes and the gear table.
package cdc_pkg;

  localparam int unsigned LenBits   = 24;
  localparam int unsigned LenW      = LenBits + 1;
  localparam int unsigned OfsW      = 48;
  localparam int unsigned MaskW     = 32;
  localparam int unsigned GearW     = 32;
  localparam int unsigned GearDepth = 256;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned HashBitsDefault = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMinSize    = 3'd0,
    CfgNormalSize = 3'd1,
    CfgMaxSize    = 3'd2,
    CfgMaskSmall  = 3'd3,
    CfgMaskLarge  = 3'd4
  } cfg_idx_e;

  // Reason a chunk was closed
  typedef enum logic [1:0] {
    CauseSmall = 2'd0,
    CauseLarge = 2'd1,
    CauseMax   = 2'd2,
    CauseEnd   = 2'd3
  } cut_cause_e;

  localparam logic [LenW-1:0]  MinSizeRst    = LenW'(2048);
  localparam logic [LenW-1:0]  NormalSizeRst = LenW'(5120);
  localparam logic [LenW-1:0]  MaxSizeRst    = LenW'(65536);
  localparam logic [MaskW-1:0] MaskSmallRst  = 32'h0000_3FFF;
  localparam logic [MaskW-1:0] MaskLargeRst  = 32'h0000_0FFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [OfsW-1:0] chunk_start;
    logic [LenW-1:0] chunk_length;
    logic [1:0]      cut_cause;
  } out_item_t;

  typedef struct packed {
    logic [LenW-1:0]  min_size;
    logic [LenW-1:0]  mask_switch;
    logic [LenW-1:0]  max_size;
    logic [MaskW-1:0] mask_small;
    logic [MaskW-1:0] mask_large;
  } cfg_t;

  typedef logic [GearW-1:0] gear_rom_t [GearDepth];

  // Fixed integer mix of the table index
  function automatic logic [GearW-1:0] gear_entry(logic [GearW-1:0] i);
    logic [GearW-1:0] h;
    h = i * 32'h9E37_79B9 + 32'h7F4A_7C15;
    h = h ^ (h >> 16);
    h = h * 32'h85EB_CA6B;
    h = h ^ (h >> 13);
    h = h * 32'hC2B2_AE35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Whole table, built at elaboration
  function automatic gear_rom_t gear_rom();
    gear_rom_t t;
    for (int k = 0; k < GearDepth; k++) begin
      t[k] = gear_entry(GearW'(k));
    end
    return t;
  endfunction

endpackage

### src/cdc_cfg_regs.sv
// Configuration register file of the chunker.
module cdc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [cdc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdc_pkg::CfgDataW-1:0]  cfg_data_i,
  output cdc_pkg::cfg_t                 cfg_o
);

  cdc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; indexes beyond the list leave every register alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cdc_pkg::cfg_idx_e'(cfg_index_i))
        cdc_pkg::CfgMinSize:    cfg_d.min_size    = cfg_data_i[cdc_pkg::LenW-1:0];
        cdc_pkg::CfgNormalSize: cfg_d.mask_switch = cfg_data_i[cdc_pkg::LenW-1:0];
        cdc_pkg::CfgMaxSize:    cfg_d.max_size    = cfg_data_i[cdc_pkg::LenW-1:0];
        cdc_pkg::CfgMaskSmall:  cfg_d.mask_small  = cfg_data_i[cdc_pkg::MaskW-1:0];
        cdc_pkg::CfgMaskLarge:  cfg_d.mask_large  = cfg_data_i[cdc_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_size    <= cdc_pkg::MinSizeRst;
      cfg_q.mask_switch <= cdc_pkg::NormalSizeRst;
      cfg_q.max_size    <= cdc_pkg::MaxSizeRst;
      cfg_q.mask_small  <= cdc_pkg::MaskSmallRst;
      cfg_q.mask_large  <= cdc_pkg::MaskLargeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/cdc_gear_rom.sv
// Gear table held as a synchronous read-only memory with a registered read word.
module cdc_gear_rom (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [7:0]                rd_addr_i,
  output logic [cdc_pkg::GearW-1:0] rd_data_o
);

  localparam cdc_pkg::gear_rom_t GearRom = cdc_pkg::gear_rom();

  logic [cdc_pkg::GearW-1:0] rd_data_q;

  // Register the read word; hold it while the consumer is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= GearRom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/cdc_cut_engine.sv
// Hash stage of the chunker: fingerprint update, cut decision and result register.
module cdc_cut_engine #(
  parameter int unsigned HashBits = cdc_pkg::HashBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  cdc_pkg::in_item_t         in_data_i,
  output logic                      gear_en_o,
  input  logic [cdc_pkg::GearW-1:0] gear_data_i,
  input  cdc_pkg::cfg_t             cfg_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output cdc_pkg::out_item_t        out_data_o
);

  localparam int unsigned LenW = cdc_pkg::LenW;
  localparam int unsigned OfsW = cdc_pkg::OfsW;

  // Stage one holds the byte whose gear word is being read
  logic s1_valid_q, s1_valid_d;
  logic s1_last_q;

  // Chunk state
  logic [HashBits-1:0] fp_q, fp_d;
  logic [LenW-1:0]     bic_q, bic_d;
  logic [OfsW-1:0]     ofs_q, ofs_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  cdc_pkg::out_item_t out_data_q, out_data_d;

  logic in_accept, out_free, s1_fire;

  logic [LenW-1:0]     len, limit, limit_raw;
  logic                hashed, match, cut;
  logic [HashBits-1:0] fp_new;
  logic [cdc_pkg::MaskW-1:0] mask;
  cdc_pkg::cut_cause_e cause;

  // Handshake: stage one moves on whenever the result register can take a transaction
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign gear_en_o  = in_accept;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // Cut decision for the byte in stage one
  always_comb begin
    len       = bic_q + LenW'(1);
    limit_raw = (cfg_i.max_size > cfg_i.min_size) ? cfg_i.max_size : cfg_i.min_size;
    limit     = (limit_raw == '0) ? LenW'(1) : limit_raw;
    hashed    = (bic_q >= cfg_i.min_size);
    fp_new    = (fp_q >> 1) + HashBits'(gear_data_i);
    if (bic_q < cfg_i.mask_switch) begin
      mask  = cfg_i.mask_small;
      cause = cdc_pkg::CauseSmall;
    end else begin
      mask  = cfg_i.mask_large;
      cause = cdc_pkg::CauseLarge;
    end
    match = hashed && ((fp_new[cdc_pkg::MaskW-1:0] & mask) == '0);
    cut   = 1'b1;
    if (!match) begin
      if (len >= limit) begin
        cause = cdc_pkg::CauseMax;
      end else if (s1_last_q) begin
        cause = cdc_pkg::CauseEnd;
      end else begin
        cut = 1'b0;
      end
    end
  end

  // Update chunk state and load a result on a cut
  always_comb begin
    fp_d        = fp_q;
    bic_d       = bic_q;
    ofs_d       = ofs_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (s1_fire) begin
      if (cut) begin
        fp_d                    = '0;
        bic_d                   = '0;
        ofs_d                   = ofs_q + OfsW'(len);
        out_valid_d             = 1'b1;
        out_data_d.chunk_start  = ofs_q;
        out_data_d.chunk_length = len;
        out_data_d.cut_cause    = cause;
      end else begin
        bic_d = len;
        if (hashed) begin
          fp_d = fp_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fp_q        <= '0;
      bic_q       <= '0;
      ofs_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fp_q        <= fp_d;
      bic_q       <= bic_d;
      ofs_q       <= ofs_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_last_q <= in_data_i.end_of_data;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/content_defined_chunker_unit.sv
// Top level of the content defined chunker (gear hash chunking, one byte per transaction).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid_i/stall_o | data_byte, end_of_data
//   out     | output    | out_valid_o/stall_i| chunk_start, chunk_length, cut_cause
//   cfg     | input     | cfg_valid_i/ready_o| register index, write data
//
// One byte per cycle sustained while the output is not stalled; the gear word is read at
// the edge that accepts a byte and the fingerprint add and cut compare follow in the next
// cycle; a result enters the result register when stage one moves on with its last byte.
// The fingerprint register loop sets the rate.
// Reset clears the chunk state and the result valid flag and loads register defaults.
// A stalled result register holds stage one, which stalls the input.
module content_defined_chunker_unit #(
  parameter int unsigned HashBits = cdc_pkg::HashBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cdc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cdc_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdc_pkg::CfgDataW-1:0]  cfg_data_i
);

  cdc_pkg::cfg_t             cfg;
  logic                      gear_en;
  logic [cdc_pkg::GearW-1:0] gear_data;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  cdc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cdc_gear_rom u_gear_rom (
    .clk_i     (clk_i),
    .rd_en_i   (gear_en),
    .rd_addr_i (in_data_i.data_byte),
    .rd_data_o (gear_data)
  );

  cdc_cut_engine #(
    .HashBits (HashBits)
  ) u_cut_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .gear_en_o   (gear_en),
    .gear_data_i (gear_data),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/cdc_checker.sv
// Port level checks of the chunker and their binding to the top level.
module cdc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cdc_pkg::out_item_t  out_data_o
);

  logic [cdc_pkg::OfsW-1:0] next_start_q;

  // Track where the next chunk must begin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_start_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      next_start_q <= out_data_o.chunk_start + cdc_pkg::OfsW'(out_data_o.chunk_length);
    end
  end

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Chunks tile the stream without gaps or overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.chunk_start == next_start_q)
    else $error("chunk start does not follow previous chunk");

  // No empty chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.chunk_length != '0)
    else $error("empty chunk reported");

  // Nothing is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind content_defined_chunker_unit cdc_checker u_cdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
